[hdl/lps_pkg.sv]
// shared definitions for the lag predictor scoreboard
// sequencer state type and state codes; no dependencies
package lps_pkg;

	typedef logic [2:0] state_t;

	localparam state_t ST_IDLE = 3'd0;
	localparam state_t ST_PRED = 3'd1;
	localparam state_t ST_CALC = 3'd2;
	localparam state_t ST_SCAN = 3'd3;
	localparam state_t ST_DONE = 3'd4;

endpackage

[hdl/lag_predictor_scoreboard.sv]
// lag predictor scoreboard top level: sequencer, counters and output register
// depends on lps_pkg and lps_ram (history symbol ring and per-lag score memory)
//
//   channel | handshake                    | payload
//   --------+------------------------------+------------------------------------------
//   in      | in_valid / in_stall (out)    | symbol, restart
//   out     | out_valid / out_stall (in)   | predicted_symbol, prediction_valid, hit,
//           |                              | winning_lag, hit_total, predicted_total,
//           |                              | longest_hit_run
//
// each symbol passes through the accept step, a winner read, a prediction step,
// one score memory read-modify-write per lag, and a history write.
// the result is registered as the history write is done and holds until taken;
// a new symbol is taken while a result waits, its end step waits for the slot.
// after reset, and on restart, the next scan writes every score back as zero.
module lag_predictor_scoreboard #(
	parameter int HISTORY_DEPTH = 128,
	parameter int SYMBOL_BITS   = 8,
	parameter int COUNT_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  symbol,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  predicted_symbol,
	output logic        prediction_valid,
	output logic        hit,
	output logic [6:0]  winning_lag,
	output logic [31:0] hit_total,
	output logic [31:0] predicted_total,
	output logic [31:0] longest_hit_run
);

	localparam int LW = $clog2(HISTORY_DEPTH);
	localparam int CW = LW + 1;
	localparam logic [LW-1:0]         LAST_LAG  = LW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0]         FULL_FILL = CW'(HISTORY_DEPTH);
	localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

	lps_pkg::state_t state_q;
	logic                   clear_pend_q;
	logic                   clear_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic [LW-1:0]          head_q;
	logic [CW-1:0]          fill_q;
	logic [LW-1:0]          winner_q;
	logic [COUNT_BITS-1:0]  hit_cnt_q;
	logic [COUNT_BITS-1:0]  pred_cnt_q;
	logic [COUNT_BITS-1:0]  run_q;
	logic [COUNT_BITS-1:0]  best_q;
	logic [COUNT_BITS-1:0]  win_score_q;
	logic [LW-1:0]          proc_lag_q;
	logic [LW-1:0]          proc_ha_q;

	logic [SYMBOL_BITS-1:0] res_pred_q;
	logic                   res_valid_q;
	logic                   res_hit_q;
	logic [LW-1:0]          res_lag_q;

	logic                   out_valid_q;
	logic [7:0]             out_pred_q;
	logic                   out_pvalid_q;
	logic                   out_hit_q;
	logic [6:0]             out_lag_q;
	logic [31:0]            out_hits_q;
	logic [31:0]            out_preds_q;
	logic [31:0]            out_best_q;

	logic                   hist_we;
	logic [LW-1:0]          hist_raddr;
	logic [SYMBOL_BITS-1:0] hist_rdata;
	logic                   score_we;
	logic [LW-1:0]          score_raddr;
	logic [COUNT_BITS-1:0]  score_rdata;
	logic [COUNT_BITS-1:0]  score_new;
	logic [COUNT_BITS-1:0]  score_old;

	logic [LW-1:0]          head_m1;
	logic [LW-1:0]          proc_dec;
	logic [CW-1:0]          win_sum;
	logic [LW-1:0]          win_ha;
	logic                   scan_match;
	logic                   pred_ok;
	logic                   pred_hit;
	logic                   last_lag;
	logic                   out_free;
	logic [COUNT_BITS-1:0]  run_inc;

	assign in_stall = (state_q != lps_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign last_lag = (proc_lag_q == LAST_LAG);

	assign head_m1  = (head_q == '0) ? LAST_LAG : head_q - 1'b1;
	assign proc_dec = (proc_ha_q == '0) ? LAST_LAG : proc_ha_q - 1'b1;

	// ring address of the winning lag: head - 1 - winner, wrapped
	assign win_sum = CW'(head_q) + CW'(HISTORY_DEPTH - 1) - CW'(winner_q);
	assign win_ha  = (win_sum >= FULL_FILL) ? LW'(win_sum - FULL_FILL) : LW'(win_sum);

	assign score_old  = clear_q ? '0 : score_rdata;
	assign scan_match = ({1'b0, proc_lag_q} < fill_q) && (hist_rdata == sym_q);
	assign score_new  = (scan_match && score_old != CNT_MAX) ? score_old + 1'b1 : score_old;

	assign pred_ok  = (fill_q != '0) && ({1'b0, winner_q} < fill_q);
	assign pred_hit = pred_ok && (hist_rdata == sym_q);
	assign run_inc  = (run_q == CNT_MAX) ? run_q : run_q + 1'b1;

	assign hist_we  = (state_q == lps_pkg::ST_DONE) && out_free;
	assign score_we = (state_q == lps_pkg::ST_SCAN);

	always_comb begin
		case (state_q)
			lps_pkg::ST_PRED: begin
				hist_raddr  = win_ha;
				score_raddr = winner_q;
			end
			lps_pkg::ST_CALC: begin
				hist_raddr  = head_m1;
				score_raddr = '0;
			end
			default: begin
				hist_raddr  = proc_dec;
				score_raddr = last_lag ? '0 : proc_lag_q + 1'b1;
			end
		endcase
	end

	lps_ram #(
		.WIDTH (SYMBOL_BITS),
		.DEPTH (HISTORY_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (head_q),
		.wdata (sym_q),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	lps_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (HISTORY_DEPTH)
	) u_score_ram (
		.clk   (clk),
		.we    (score_we),
		.waddr (proc_lag_q),
		.wdata (score_new),
		.raddr (score_raddr),
		.rdata (score_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lps_pkg::ST_IDLE;
			clear_pend_q <= 1'b1;
			clear_q      <= 1'b0;
			head_q       <= '0;
			fill_q       <= '0;
			winner_q     <= '0;
			hit_cnt_q    <= '0;
			pred_cnt_q   <= '0;
			run_q        <= '0;
			best_q       <= '0;
			proc_lag_q   <= '0;
			proc_ha_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (hist_we) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				lps_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q      <= lps_pkg::ST_PRED;
						clear_q      <= restart || clear_pend_q;
						clear_pend_q <= 1'b0;
						if (restart || clear_pend_q) begin
							fill_q     <= '0;
							winner_q   <= '0;
							hit_cnt_q  <= '0;
							pred_cnt_q <= '0;
							run_q      <= '0;
							best_q     <= '0;
						end
					end
				end
				lps_pkg::ST_PRED: begin
					state_q <= lps_pkg::ST_CALC;
				end
				lps_pkg::ST_CALC: begin
					// history ram now returns the symbol at the winning lag
					if (fill_q != '0) begin
						if (pred_cnt_q != CNT_MAX) begin
							pred_cnt_q <= pred_cnt_q + 1'b1;
						end
						if (pred_hit) begin
							if (hit_cnt_q != CNT_MAX) begin
								hit_cnt_q <= hit_cnt_q + 1'b1;
							end
							run_q <= run_inc;
							if (run_inc > best_q) begin
								best_q <= run_inc;
							end
						end else begin
							run_q <= '0;
						end
					end
					proc_lag_q <= '0;
					proc_ha_q  <= head_m1;
					state_q    <= lps_pkg::ST_SCAN;
				end
				lps_pkg::ST_SCAN: begin
					if (scan_match && score_new >= win_score_q) begin
						winner_q <= proc_lag_q;
					end
					proc_lag_q <= last_lag ? '0 : proc_lag_q + 1'b1;
					proc_ha_q  <= proc_dec;
					if (last_lag) begin
						state_q <= lps_pkg::ST_DONE;
					end
				end
				lps_pkg::ST_DONE: begin
					if (out_free) begin
						head_q  <= (head_q == LAST_LAG) ? '0 : head_q + 1'b1;
						if (fill_q != FULL_FILL) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= lps_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lps_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == lps_pkg::ST_IDLE && in_valid) begin
			sym_q <= SYMBOL_BITS'(symbol);
		end
		if (state_q == lps_pkg::ST_CALC) begin
			res_pred_q  <= pred_ok ? hist_rdata : '0;
			res_valid_q <= pred_ok;
			res_hit_q   <= pred_hit;
			res_lag_q   <= winner_q;
			win_score_q <= score_old;
		end
		if (state_q == lps_pkg::ST_SCAN && scan_match && score_new >= win_score_q) begin
			win_score_q <= score_new;
		end
		if (hist_we) begin
			out_pred_q   <= 8'(res_pred_q);
			out_pvalid_q <= res_valid_q;
			out_hit_q    <= res_hit_q;
			out_lag_q    <= 7'(res_lag_q);
			out_hits_q   <= 32'(hit_cnt_q);
			out_preds_q  <= 32'(pred_cnt_q);
			out_best_q   <= 32'(best_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign predicted_symbol = out_pred_q;
	assign prediction_valid = out_pvalid_q;
	assign hit              = out_hit_q;
	assign winning_lag      = out_lag_q;
	assign hit_total        = out_hits_q;
	assign predicted_total  = out_preds_q;
	assign longest_hit_run  = out_best_q;

endmodule

[hdl/lps_ram.sv]
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module lps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[tb/lag_predictor_scoreboard_test.sv]
// testbench for lag_predictor_scoreboard: directed table, then periodic and noisy symbol runs
// results are checked against an in-bench lag predictor; needs only the block's rtl
`timescale 1ns / 100ps

module lag_predictor_scoreboard_test;

	localparam int LAGS           = 128;
	localparam int N_DIRECTED     = 21;
	localparam int N_RANDOM       = 400;
	localparam int N_QUIET        = 50;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [7:0]  guess;
		logic        guess_ok;
		logic        hit_flag;
		logic [6:0]  lag;
		logic [31:0] hits;
		logic [31:0] guesses;
		logic [31:0] best_run;
	} outcome_t;

	typedef struct packed {
		logic [7:0] sym;
		logic       rst;
		logic       fixed;
		outcome_t   want;
	} stim_row_t;

	localparam outcome_t NO_WANT = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  symbol = 8'd0;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  predicted_symbol;
	logic        prediction_valid;
	logic        hit;
	logic [6:0]  winning_lag;
	logic [31:0] hit_total;
	logic [31:0] predicted_total;
	logic [31:0] longest_hit_run;

	// predictor state
	logic [7:0]  hist_sym [LAGS];
	logic        hist_ok [LAGS];
	logic [31:0] lag_hits [LAGS];
	int          winner = 0;
	logic [31:0] hit_count = '0;
	logic [31:0] guess_count = '0;
	logic [31:0] run_now = '0;
	logic [31:0] run_best = '0;

	outcome_t    pending_outcomes [$];
	stim_row_t   directed_rows [N_DIRECTED];
	int          errors = 0;
	int          results_seen = 0;
	int          stall_left = 0;
	int          idle_cycles = 0;
	bit          quiet = 1'b0;

	lag_predictor_scoreboard DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.symbol           (symbol),
		.restart          (restart),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.predicted_symbol (predicted_symbol),
		.prediction_valid (prediction_valid),
		.hit              (hit),
		.winning_lag      (winning_lag),
		.hit_total        (hit_total),
		.predicted_total  (predicted_total),
		.longest_hit_run  (longest_hit_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] sat_bump(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic outcome_t predict_symbol(input logic [7:0] sym, input logic rst);
		outcome_t o;
		int w;
		o = '0;
		if (rst) begin
			for (int d = 0; d < LAGS; d++) begin
				hist_sym[d] = '0;
				hist_ok[d] = 1'b0;
				lag_hits[d] = '0;
			end
			winner = 0;
			hit_count = '0;
			guess_count = '0;
			run_now = '0;
			run_best = '0;
		end
		w = winner;
		o.lag = 7'(w);
		// nothing to predict from until lag 0 holds a symbol
		if (hist_ok[0]) begin
			if (hist_ok[w]) begin
				o.guess = hist_sym[w];
				o.guess_ok = 1'b1;
				o.hit_flag = (hist_sym[w] == sym);
			end
			guess_count = sat_bump(guess_count);
			if (o.hit_flag) begin
				hit_count = sat_bump(hit_count);
				run_now = sat_bump(run_now);
				if (run_now > run_best)
					run_best = run_now;
			end else begin
				run_now = '0;
			end
			// ascending scan, a tie moves the winner to the later lag
			for (int d = 0; d < LAGS; d++) begin
				if (hist_ok[d] && hist_sym[d] == sym) begin
					lag_hits[d] = sat_bump(lag_hits[d]);
					if (lag_hits[d] >= lag_hits[w])
						w = d;
				end
			end
			winner = w;
		end
		for (int d = LAGS - 1; d > 0; d--) begin
			hist_sym[d] = hist_sym[d - 1];
			hist_ok[d] = hist_ok[d - 1];
		end
		hist_sym[0] = sym;
		hist_ok[0] = 1'b1;
		o.hits = hit_count;
		o.guesses = guess_count;
		o.best_run = run_best;
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	// one input transfer; the table value overrides the predictor on fixed rows
	task automatic send_symbol(input logic [7:0] sym, input logic rst, input logic fixed,
			input outcome_t want, input int gap_odds);
		outcome_t model;
		if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		symbol = sym;
		restart = rst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		model = predict_symbol(sym, rst);
		pending_outcomes.push_back(fixed ? want : model);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (quiet) begin
			out_stall = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 5);
			out_stall = 1'b1;
		end else begin
			out_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing pending",
					results_seen));
			end else begin
				want = pending_outcomes.pop_front();
				check_field("predicted_symbol", 32'(predicted_symbol), 32'(want.guess));
				check_field("prediction_valid", 32'(prediction_valid), 32'(want.guess_ok));
				check_field("hit", 32'(hit), 32'(want.hit_flag));
				check_field("winning_lag", 32'(winning_lag), 32'(want.lag));
				check_field("hit_total", hit_total, want.hits);
				check_field("predicted_total", predicted_total, want.guesses);
				check_field("longest_hit_run", longest_hit_run, want.best_run);
			end
			results_seen++;
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("lag_predictor_scoreboard test failed");
		$finish;
	end

	initial begin
		logic [7:0] pattern [LAGS];
		logic [7:0] sym;
		logic       rst;
		int         seg_left;
		int         period;
		int         pos;
		int         noise_pct;
		int         gap_odds;

		for (int d = 0; d < LAGS; d++) begin
			hist_sym[d] = '0;
			hist_ok[d] = 1'b0;
			lag_hits[d] = '0;
			pattern[d] = '0;
		end
		seg_left = 0;
		period = 1;
		pos = 0;
		noise_pct = 0;
		gap_odds = 0;

		// first symbol, repeats, a miss, restart; then alternation, bit patterns and a final restart
		directed_rows = '{
			{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 7'd0, 32'd0, 32'd0, 32'd0},
			{8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1, 7'd0, 32'd1, 32'd1, 32'd1},
			{8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1, 7'd0, 32'd2, 32'd2, 32'd2},
			{8'hFF, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 7'd0, 32'd2, 32'd3, 32'd2},
			{8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 7'd0, 32'd0, 32'd0, 32'd0},
			{8'h00, 1'b0, 1'b0, NO_WANT},
			{8'hFF, 1'b0, 1'b0, NO_WANT},
			{8'h00, 1'b0, 1'b0, NO_WANT},
			{8'hFF, 1'b0, 1'b0, NO_WANT},
			{8'h00, 1'b0, 1'b0, NO_WANT},
			{8'hFF, 1'b0, 1'b0, NO_WANT},
			{8'h00, 1'b0, 1'b0, NO_WANT},
			{8'h55, 1'b0, 1'b0, NO_WANT},
			{8'hAA, 1'b0, 1'b0, NO_WANT},
			{8'h55, 1'b0, 1'b0, NO_WANT},
			{8'hAA, 1'b0, 1'b0, NO_WANT},
			{8'h01, 1'b0, 1'b0, NO_WANT},
			{8'h80, 1'b0, 1'b0, NO_WANT},
			{8'h7F, 1'b0, 1'b0, NO_WANT},
			{8'hFE, 1'b0, 1'b0, NO_WANT},
			{8'h80, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 7'd0, 32'd0, 32'd0, 32'd0}
		};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_symbol(directed_rows[i].sym, directed_rows[i].rst, directed_rows[i].fixed,
				directed_rows[i].want, 3);

		// segments of a repeating pattern with noise mixed in; some are pure noise
		for (int i = 0; i < N_RANDOM; i++) begin
			rst = 1'b0;
			if (seg_left == 0) begin
				period = ($urandom_range(0, 5) == 0) ? $urandom_range(9, LAGS)
					: $urandom_range(1, 8);
				seg_left = (period > 8) ? period + $urandom_range(8, 40)
					: $urandom_range(8, 48);
				noise_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(0, 15);
				gap_odds = $urandom_range(0, 1) ? 4 : 0;
				for (int d = 0; d < period; d++)
					pattern[d] = 8'($urandom);
				pos = 0;
				rst = ($urandom_range(0, 2) == 0);
			end
			if (i == N_RANDOM - N_QUIET)
				quiet = 1'b1;
			sym = ($urandom_range(0, 99) < noise_pct) ? 8'($urandom) : pattern[pos % period];
			if ($urandom_range(0, 63) == 0)
				rst = 1'b1;
			send_symbol(sym, rst, 1'b0, NO_WANT, quiet ? 0 : gap_odds);
			pos++;
			seg_left--;
		end
		in_valid = 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		// watch for a stray transfer after the last expected one
		repeat (LAGS + 16) @(posedge clk);
		if (errors == 0)
			$display("lag_predictor_scoreboard test passed");
		else
			$display("lag_predictor_scoreboard test failed");
		$finish;
	end

endmodule

[sim.f]
hdl/lps_pkg.sv
hdl/lps_ram.sv
hdl/lag_predictor_scoreboard.sv
tb/lag_predictor_scoreboard_test.sv
